// ----- hdl/shc_pkg.sv -----
// Shared constants, types and helpers for the split class histogram unit.
package shc_pkg;

    localparam int MAX_BAGS    = 16;
    localparam int MAX_CLASSES = 16;
    localparam int FRAC_BITS   = 16;
    localparam int ACC_W       = 24 + FRAC_BITS;
    localparam int WGT_W       = 32;
    localparam int BAG_W       = $clog2(MAX_BAGS);
    localparam int CLS_W       = $clog2(MAX_CLASSES);
    localparam int ADDR_W      = BAG_W + CLS_W;
    localparam int CNT_W       = 5;
    localparam int CFG_W       = 32;
    localparam int CIDX_W      = 2;
    localparam int SCAN_LEN    = (MAX_BAGS > MAX_CLASSES) ? MAX_BAGS : MAX_CLASSES;

    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_ADD   = 3'd1;
    localparam logic [2:0] OP_SUB   = 3'd2;
    localparam logic [2:0] OP_SHIFT = 3'd3;
    localparam logic [2:0] OP_QUERY = 3'd4;

    localparam logic [CIDX_W-1:0] CFG_BAGS    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_CLASSES = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_MIN     = 2'd2;

    localparam logic [CNT_W-1:0] NO_BAG = 5'd16;

    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic signed [ACC_W:0]   t_delta;

    typedef struct packed {
        logic              clr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [ADDR_W-1:0] raddr;
    } t_mem_ctl;

    // True when a signed accumulator value is strictly positive.
    function automatic logic is_pos(input t_acc v);
        return !v[ACC_W-1] && (v != '0);
    endfunction

endpackage

// ----- hdl/shc_item_if.sv -----
// Input item channel of the split class histogram unit.
interface shc_item_if import shc_pkg::*;;
    logic             valid;
    logic             ready;
    logic [2:0]       opcode;
    logic [3:0]       bag;
    logic [3:0]       to_bag;
    logic [3:0]       class_index;
    logic [WGT_W-1:0] weight;

    modport source (output valid, opcode, bag, to_bag, class_index, weight, input ready);
    modport sink   (input valid, opcode, bag, to_bag, class_index, weight, output ready);
endinterface

// ----- hdl/shc_result_if.sv -----
// Result channel of the split class histogram unit.
interface shc_result_if import shc_pkg::*;;
    logic             valid;
    logic             ready;
    logic [ACC_W-1:0] cell_weight;
    logic [ACC_W-1:0] bag_weight;
    logic [ACC_W-1:0] class_weight;
    logic [ACC_W-1:0] total_weight;
    logic [3:0]       best_class;
    logic [3:0]       best_class_in_bag;
    logic [ACC_W-1:0] bag_correct;
    logic [ACC_W-1:0] bag_incorrect;
    logic [4:0]       heaviest_bag;
    logic             split_ok;
    logic [4:0]       nonempty_bags;
    logic [4:0]       nonempty_classes;

    modport source (output valid, cell_weight, bag_weight, class_weight, total_weight,
                    best_class, best_class_in_bag, bag_correct, bag_incorrect,
                    heaviest_bag, split_ok, nonempty_bags, nonempty_classes,
                    input ready);
    modport sink   (input valid, cell_weight, bag_weight, class_weight, total_weight,
                    best_class, best_class_in_bag, bag_correct, bag_incorrect,
                    heaviest_bag, split_ok, nonempty_bags, nonempty_classes,
                    output ready);
endinterface

// ----- hdl/shc_sat_add.sv -----
// Shared saturating adder for all accumulator updates.
module shc_sat_add import shc_pkg::*; (
    input  t_acc   i_a,
    input  t_delta i_b,
    output t_acc   o_sum
);
    logic [ACC_W+1:0] sum;

    assign sum = {{2{i_a[ACC_W-1]}}, i_a} + {i_b[ACC_W], i_b};

    always_comb begin
        if ((sum[ACC_W+1:ACC_W-1] == 3'b000) || (sum[ACC_W+1:ACC_W-1] == 3'b111)) begin
            o_sum = t_acc'(sum[ACC_W-1:0]);
        end else if (sum[ACC_W+1]) begin
            o_sum = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            o_sum = {1'b0, {(ACC_W-1){1'b1}}};
        end
    end
endmodule

// ----- hdl/shc_cell_mem.sv -----
// Bag-by-class count memory with per-entry valid bits for instant clearing.
module shc_cell_mem import shc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mem_ctl i_ctl,
    input  t_acc     i_wdata,
    output t_acc     o_rdata
);
    localparam int DEPTH = 2 ** ADDR_W;

    t_acc             r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    t_acc             r_rdata;
    logic             r_rvld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_vld <= '0;
        end else if (i_ctl.we) begin
            r_vld[i_ctl.waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_ctl.raddr];
        r_rvld  <= r_vld[i_ctl.raddr];
    end

    // An entry never written since the last clear reads as zero.
    assign o_rdata = r_rvld ? r_rdata : '0;
endmodule

// ----- hdl/split_class_histogram_unit.sv -----
// Top level of the split class histogram unit: sequencer, totals and result register.
//
//  Channel    Direction  Handshake          Contents
//  i_item     in         valid / ready      opcode, bag, to_bag, class_index, weight
//  o_result   out        valid / ready      updated counts, argmax classes, bag summary
//  i_cfg_*    in         write enable only  bags_in_use, classes_in_use, min_objects
//
// Each item is accepted in the idle state and passes through up to six update steps
// that share the single saturating adder and the cell memory, then a scan over
// classes, bags and the cells of the addressed bag (the scan runs longer
// when all sixteen classes are active), and the states S_CORR, S_CORR2, S_FIN and
// S_DONE fetch the correct weight and the cell and finish.
// Input ready is high only while the sequencer is idle. A finished result sits in
// the output register while the next item is already being accepted; the unit only
// stalls at its final step when that register is still occupied.
// Reset is synchronous and active low; the cell table is cleared through its valid
// bits at once, so no clearing pass is needed.
module split_class_histogram_unit import shc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    shc_item_if.sink          i_item,
    shc_result_if.source      o_result
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_RD1   = 4'd2;
    localparam logic [3:0] S_WR1   = 4'd3;
    localparam logic [3:0] S_RD2   = 4'd4;
    localparam logic [3:0] S_WR2   = 4'd5;
    localparam logic [3:0] S_BAG1  = 4'd6;
    localparam logic [3:0] S_BAG2  = 4'd7;
    localparam logic [3:0] S_CLS   = 4'd8;
    localparam logic [3:0] S_TOT   = 4'd9;
    localparam logic [3:0] S_SCAN  = 4'd10;
    localparam logic [3:0] S_CORR  = 4'd11;
    localparam logic [3:0] S_CORR2 = 4'd12;
    localparam logic [3:0] S_FIN   = 4'd13;
    localparam logic [3:0] S_DONE  = 4'd14;

    // Configuration registers.
    logic [CNT_W-1:0] r_bags_cfg;
    logic [CNT_W-1:0] r_cls_cfg;
    logic [WGT_W-1:0] r_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bags_cfg <= CNT_W'(2);
            r_cls_cfg  <= CNT_W'(2);
            r_min      <= WGT_W'(131072);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BAGS:    r_bags_cfg <= i_cfg_data[CNT_W-1:0];
                CFG_CLASSES: r_cls_cfg  <= i_cfg_data[CNT_W-1:0];
                CFG_MIN:     r_min      <= i_cfg_data[WGT_W-1:0];
                default: ;
            endcase
        end
    end

    // Active counts, clamped to one..maximum.
    logic [CNT_W-1:0] nb, nc;
    always_comb begin
        if (r_bags_cfg == '0)                   nb = CNT_W'(1);
        else if (r_bags_cfg > CNT_W'(MAX_BAGS)) nb = CNT_W'(MAX_BAGS);
        else                                    nb = r_bags_cfg;
        if (r_cls_cfg == '0)                      nc = CNT_W'(1);
        else if (r_cls_cfg > CNT_W'(MAX_CLASSES)) nc = CNT_W'(MAX_CLASSES);
        else                                      nc = r_cls_cfg;
    end

    logic [3:0]       r_state;
    logic [2:0]       r_op;
    logic [BAG_W-1:0] r_b, r_tb;
    logic [CLS_W-1:0] r_c;
    logic [WGT_W-1:0] r_w;
    logic             r_bok, r_cok;
    logic [CNT_W-1:0] r_nb, r_nc;

    t_acc r_bag_tot [MAX_BAGS];
    t_acc r_cls_tot [MAX_CLASSES];
    t_acc r_grand;

    // Scan state.
    logic [CNT_W-1:0] r_k;
    logic             r_pend;
    logic [CLS_W-1:0] r_cidx;
    t_acc             r_cmax, r_bmax, r_cellmax;
    logic [CLS_W-1:0] r_best, r_bib;
    logic [CNT_W-1:0] r_heavy, r_necls, r_nebags;
    logic [1:0]       r_okcnt;
    t_acc             r_bw, r_clsw, r_correct, r_cellw, r_inc;

    // Result register.
    logic             r_ovld;
    t_acc             r_o_cell, r_o_bag, r_o_cls, r_o_tot, r_o_corr, r_o_inc;
    logic [3:0]       r_o_best, r_o_bib;
    logic [4:0]       r_o_heavy, r_o_nebags, r_o_necls;
    logic             r_o_split;

    logic accept, out_free;
    assign i_item.ready = (r_state == S_IDLE);
    assign accept       = i_item.valid && i_item.ready;
    assign out_free     = !r_ovld || o_result.ready;

    // Single read port on each totals array.
    logic [BAG_W-1:0] bag_ra;
    logic [CLS_W-1:0] cls_ra;
    t_acc             bag_rd, cls_rd;
    always_comb begin
        if (r_state == S_SCAN)      bag_ra = r_k[BAG_W-1:0];
        else if (r_state == S_BAG2) bag_ra = r_tb;
        else                        bag_ra = r_b;
        cls_ra = (r_state == S_SCAN) ? r_k[CLS_W-1:0] : r_c;
    end
    assign bag_rd = r_bag_tot[bag_ra];
    assign cls_rd = r_cls_tot[cls_ra];

    // Shared adder operands.
    t_acc   mem_rdata, add_a, add_sum;
    t_delta w_pos, w_neg, add_b;
    logic   upd_neg;
    assign w_pos   = t_delta'({{(ACC_W+1-WGT_W){1'b0}}, r_w});
    assign w_neg   = -w_pos;
    assign upd_neg = (r_op != OP_ADD);

    always_comb begin
        add_a = '0;
        add_b = '0;
        unique case (r_state)
            S_WR1:  begin add_a = mem_rdata; add_b = upd_neg ? w_neg : w_pos; end
            S_WR2:  begin add_a = mem_rdata; add_b = w_pos; end
            S_BAG1: begin add_a = bag_rd;    add_b = upd_neg ? w_neg : w_pos; end
            S_BAG2: begin add_a = bag_rd;    add_b = w_pos; end
            S_CLS:  begin add_a = cls_rd;    add_b = (r_op == OP_SUB) ? w_neg : w_pos; end
            S_TOT:  begin add_a = r_grand;   add_b = (r_op == OP_SUB) ? w_neg : w_pos; end
            S_FIN:  begin add_a = r_bw;      add_b = -t_delta'({r_correct[ACC_W-1], r_correct}); end
            default: ;
        endcase
    end

    shc_sat_add u_add (
        .i_a   (add_a),
        .i_b   (add_b),
        .o_sum (add_sum)
    );

    // Final best class inside the bag: falls back to the overall winner.
    logic [CLS_W-1:0] bib_final;
    assign bib_final = (r_bok && is_pos(r_bw)) ? r_bib : r_best;

    // Cell memory control.
    t_mem_ctl mem_ctl;
    always_comb begin
        mem_ctl.clr   = (r_state == S_CLR);
        mem_ctl.we    = (r_state == S_WR1) || (r_state == S_WR2);
        mem_ctl.waddr = (r_state == S_WR2) ? {r_tb, r_c} : {r_b, r_c};
        unique case (r_state)
            S_RD2:   mem_ctl.raddr = {r_tb, r_c};
            S_SCAN:  mem_ctl.raddr = {r_b, r_k[CLS_W-1:0]};
            S_CORR:  mem_ctl.raddr = {r_b, bib_final};
            default: mem_ctl.raddr = {r_b, r_c};
        endcase
    end

    shc_cell_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mem_ctl),
        .i_wdata (add_sum),
        .o_rdata (mem_rdata)
    );

    // Sequencer.
    logic in_b, in_c, in_tb, upd_ok, shf_ok;
    assign in_b   = CNT_W'(i_item.bag) < nb;
    assign in_tb  = CNT_W'(i_item.to_bag) < nb;
    assign in_c   = CNT_W'(i_item.class_index) < nc;
    assign upd_ok = ((i_item.opcode == OP_ADD) || (i_item.opcode == OP_SUB)) && in_b && in_c;
    assign shf_ok = (i_item.opcode == OP_SHIFT) && in_b && in_tb && in_c;

    logic  scan_end;
    assign scan_end = (r_k == CNT_W'(SCAN_LEN)) && !r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_item.opcode == OP_CLEAR) r_state <= S_CLR;
                        else if (upd_ok || shf_ok)     r_state <= S_RD1;
                        else                           r_state <= S_SCAN;
                    end
                end
                S_CLR:   r_state <= S_SCAN;
                S_RD1:   r_state <= S_WR1;
                S_WR1:   r_state <= (r_op == OP_SHIFT) ? S_RD2 : S_BAG1;
                S_RD2:   r_state <= S_WR2;
                S_WR2:   r_state <= S_BAG1;
                S_BAG1:  r_state <= (r_op == OP_SHIFT) ? S_BAG2 : S_CLS;
                S_BAG2:  r_state <= S_SCAN;
                S_CLS:   r_state <= S_TOT;
                S_TOT:   r_state <= S_SCAN;
                S_SCAN:  r_state <= scan_end ? S_CORR : S_SCAN;
                S_CORR:  r_state <= S_CORR2;
                S_CORR2: r_state <= S_FIN;
                S_FIN:   r_state <= S_DONE;
                S_DONE:  r_state <= out_free ? S_IDLE : S_DONE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Totals: cleared by reset and by the clear opcode, updated through the adder.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (r_state == S_CLR)) begin
            for (int i = 0; i < MAX_BAGS; i++)    r_bag_tot[i] <= '0;
            for (int i = 0; i < MAX_CLASSES; i++) r_cls_tot[i] <= '0;
            r_grand <= '0;
        end else begin
            if ((r_state == S_BAG1) || (r_state == S_BAG2)) r_bag_tot[bag_ra] <= add_sum;
            if (r_state == S_CLS) r_cls_tot[cls_ra] <= add_sum;
            if (r_state == S_TOT) r_grand <= add_sum;
        end
    end

    // Item fields, scan accumulators and intermediate results.
    t_acc min_ext;
    assign min_ext = t_acc'({{(ACC_W-WGT_W){1'b0}}, r_min});

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op      <= i_item.opcode;
            r_b       <= i_item.bag;
            r_tb      <= i_item.to_bag;
            r_c       <= i_item.class_index;
            r_w       <= i_item.weight;
            r_bok     <= in_b;
            r_cok     <= in_c;
            r_nb      <= nb;
            r_nc      <= nc;
            r_k       <= '0;
            r_pend    <= 1'b0;
            r_cidx    <= '0;
            r_cmax    <= '0;
            r_bmax    <= '0;
            r_cellmax <= '0;
            r_best    <= '0;
            r_bib     <= '0;
            r_heavy   <= NO_BAG;
            r_necls   <= '0;
            r_nebags  <= '0;
            r_okcnt   <= '0;
            r_bw      <= '0;
            r_clsw    <= '0;
        end else if (r_state == S_SCAN) begin
            if (r_k != CNT_W'(SCAN_LEN)) r_k <= r_k + CNT_W'(1);
            r_pend <= r_k < r_nc;
            r_cidx <= r_k[CLS_W-1:0];
            if (r_k < r_nc) begin
                if (cls_rd > r_cmax) begin
                    r_cmax <= cls_rd;
                    r_best <= r_k[CLS_W-1:0];
                end
                if (is_pos(cls_rd)) r_necls <= r_necls + CNT_W'(1);
                if (r_k[CLS_W-1:0] == r_c) r_clsw <= cls_rd;
            end
            if (r_k < r_nb) begin
                if (bag_rd >= r_bmax) begin
                    r_bmax  <= bag_rd;
                    r_heavy <= r_k;
                end
                if ((bag_rd >= min_ext) && (r_okcnt != 2'd2)) r_okcnt <= r_okcnt + 2'd1;
                if (is_pos(bag_rd)) r_nebags <= r_nebags + CNT_W'(1);
                if (r_k[BAG_W-1:0] == r_b) r_bw <= bag_rd;
            end
            // Cell compare uses the registered memory read, with r_pend and r_cidx registered alongside it.
            if (r_pend && (mem_rdata > r_cellmax)) begin
                r_cellmax <= mem_rdata;
                r_bib     <= r_cidx;
            end
        end else if (r_state == S_CORR) begin
            r_bib <= bib_final;
        end
        if (r_state == S_CORR2) r_correct <= r_bok ? mem_rdata : '0;
        if (r_state == S_FIN) begin
            r_cellw <= (r_bok && r_cok) ? mem_rdata : '0;
            r_inc   <= add_sum;
        end
    end

    // Output register.
    logic load_out;
    assign load_out = (r_state == S_DONE) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (load_out) begin
            r_ovld <= 1'b1;
        end else if (o_result.ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_cell   <= r_cellw;
            r_o_bag    <= r_bw;
            r_o_cls    <= r_cok ? r_clsw : '0;
            r_o_tot    <= r_grand;
            r_o_best   <= 4'(r_best);
            r_o_bib    <= 4'(r_bib);
            r_o_corr   <= r_correct;
            r_o_inc    <= r_inc;
            r_o_heavy  <= r_heavy;
            r_o_split  <= (r_okcnt == 2'd2);
            r_o_nebags <= r_nebags;
            r_o_necls  <= r_necls;
        end
    end

    assign o_result.valid             = r_ovld;
    assign o_result.cell_weight       = r_o_cell;
    assign o_result.bag_weight        = r_o_bag;
    assign o_result.class_weight      = r_o_cls;
    assign o_result.total_weight      = r_o_tot;
    assign o_result.best_class        = r_o_best;
    assign o_result.best_class_in_bag = r_o_bib;
    assign o_result.bag_correct       = r_o_corr;
    assign o_result.bag_incorrect     = r_o_inc;
    assign o_result.heaviest_bag      = r_o_heavy;
    assign o_result.split_ok          = r_o_split;
    assign o_result.nonempty_bags     = r_o_nebags;
    assign o_result.nonempty_classes  = r_o_necls;
endmodule

// ----- hdl/shc_checker.sv -----
// Port-level assertions for the split class histogram unit and their bind.
module shc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);
    logic       in_xfer, out_xfer;
    logic [1:0] r_open;

    assign in_xfer  = i_in_valid && i_in_ready;
    assign out_xfer = i_out_valid && i_out_ready;

    // Items accepted whose result has not yet been transferred.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= r_open + 2'(in_xfer) - 2'(out_xfer);
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("item accepted while unit busy");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped before transfer");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_open != 2'd0))
        else $error("result without an item outstanding");
endmodule

bind split_class_histogram_unit shc_checker u_shc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready)
);

// ----- tb/split_class_histogram_unit_tb.sv -----
// Self-checking testbench for the split class histogram unit: directed table plus random traffic.
module split_class_histogram_unit_tb;
    import shc_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CIDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    shc_item_if   item_ch ();
    shc_result_if res_ch ();

    split_class_histogram_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_ch.sink),
        .o_result   (res_ch.source)
    );

    // One expected summary of the table after an item.
    typedef struct {
        logic [ACC_W-1:0] cell_weight;
        logic [ACC_W-1:0] bag_weight;
        logic [ACC_W-1:0] class_weight;
        logic [ACC_W-1:0] total_weight;
        logic [3:0]       best_class;
        logic [3:0]       best_class_in_bag;
        logic [ACC_W-1:0] bag_correct;
        logic [ACC_W-1:0] bag_incorrect;
        logic [4:0]       heaviest_bag;
        logic             split_ok;
        logic [4:0]       nonempty_bags;
        logic [4:0]       nonempty_classes;
    } t_summary;

    // One row of the directed table; chk_total is set where the grand total is
    // obvious by inspection, and is compared on top of the predictor.
    typedef struct {
        logic [2:0]       op;
        logic [3:0]       bag;
        logic [3:0]       to_bag;
        logic [3:0]       cls;
        logic [WGT_W-1:0] wgt;
        bit               chk_total;
        logic [ACC_W-1:0] total;
    } t_row;

    localparam logic [2:0] OP_UNUSED = 3'd5;
    localparam logic [2:0] OP_SPARE = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;

    // Shadow of the table and configuration.
    t_acc        hist_cell [MAX_BAGS*MAX_CLASSES];
    t_acc        hist_bag [MAX_BAGS];
    t_acc        hist_cls [MAX_CLASSES];
    t_acc        hist_grand;
    logic [4:0]  cfg_bags;
    logic [4:0]  cfg_classes;
    logic [31:0] cfg_min;

    t_summary pending_summaries [$];
    int  fail_count;
    int  cycle_count;
    bit  stim_done;
    int  res_stall_max;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Saturate a wide signed value to the accumulator range.
    function automatic t_acc sat_acc(input logic signed [ACC_W+1:0] v);
        logic signed [ACC_W+1:0] hi;
        logic signed [ACC_W+1:0] lo;
        hi = (ACC_W+2)'(({ACC_W{1'b0}} | {1'b0, {(ACC_W-1){1'b1}}}));
        lo = -hi - 1;
        if (v > hi) return t_acc'(hi);
        if (v < lo) return t_acc'(lo);
        return t_acc'(v);
    endfunction

    function automatic t_acc acc_move(input t_acc a, input logic [WGT_W-1:0] w, input bit neg);
        logic signed [ACC_W+1:0] d;
        d = $signed({2'b00, {(ACC_W-WGT_W){1'b0}}, w});
        if (neg) d = -d;
        return sat_acc($signed({{2{a[ACC_W-1]}}, a}) + d);
    endfunction

    function automatic int active_limit(input logic [4:0] v, input int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // Apply one item to the shadow table and produce the summary it returns.
    function automatic t_summary apply_histogram_item(input logic [2:0] op,
            input logic [3:0] b, input logic [3:0] tb, input logic [3:0] c,
            input logic [WGT_W-1:0] w);
        t_summary s;
        int nb;
        int nc;
        bit bok;
        bit cok;
        bit tok;
        t_acc mx;
        t_acc bw;
        t_acc corr;
        int best;
        int bib;
        int heavy;
        int okcnt;
        int neb;
        int nec;
        nb = active_limit(cfg_bags, MAX_BAGS);
        nc = active_limit(cfg_classes, MAX_CLASSES);
        bok = b < nb;
        cok = c < nc;
        tok = tb < nb;
        if (op == OP_CLEAR) begin
            foreach (hist_cell[k]) hist_cell[k] = '0;
            foreach (hist_bag[k]) hist_bag[k] = '0;
            foreach (hist_cls[k]) hist_cls[k] = '0;
            hist_grand = '0;
        end else if ((op == OP_ADD || op == OP_SUB) && bok && cok) begin
            hist_cell[b*MAX_CLASSES+c] = acc_move(hist_cell[b*MAX_CLASSES+c], w, op == OP_SUB);
            hist_bag[b] = acc_move(hist_bag[b], w, op == OP_SUB);
            hist_cls[c] = acc_move(hist_cls[c], w, op == OP_SUB);
            hist_grand = acc_move(hist_grand, w, op == OP_SUB);
        end else if (op == OP_SHIFT && bok && tok && cok) begin
            hist_cell[b*MAX_CLASSES+c] = acc_move(hist_cell[b*MAX_CLASSES+c], w, 1'b1);
            hist_cell[tb*MAX_CLASSES+c] = acc_move(hist_cell[tb*MAX_CLASSES+c], w, 1'b0);
            hist_bag[b] = acc_move(hist_bag[b], w, 1'b1);
            hist_bag[tb] = acc_move(hist_bag[tb], w, 1'b0);
        end

        mx = '0;
        best = 0;
        nec = 0;
        for (int i = 0; i < nc; i++) begin
            if (hist_cls[i] > mx) begin
                mx = hist_cls[i];
                best = i;
            end
            if (hist_cls[i] > 0) nec++;
        end
        bib = best;
        bw = bok ? hist_bag[b] : '0;
        if (bok && bw > 0) begin
            mx = '0;
            bib = 0;
            for (int i = 0; i < nc; i++) begin
                if (hist_cell[b*MAX_CLASSES+i] > mx) begin
                    mx = hist_cell[b*MAX_CLASSES+i];
                    bib = i;
                end
            end
        end
        corr = bok ? hist_cell[b*MAX_CLASSES+bib] : '0;
        mx = '0;
        heavy = NO_BAG;
        okcnt = 0;
        neb = 0;
        for (int i = 0; i < nb; i++) begin
            if (hist_bag[i] >= mx) begin
                mx = hist_bag[i];
                heavy = i;
            end
            // Compare in a wider signed space so the full 32-bit minimum works.
            if ($signed({{2{hist_bag[i][ACC_W-1]}}, hist_bag[i]}) >=
                $signed({2'b00, {(ACC_W-32){1'b0}}, cfg_min})) okcnt++;
            if (hist_bag[i] > 0) neb++;
        end
        s.cell_weight = (bok && cok) ? hist_cell[b*MAX_CLASSES+c] : '0;
        s.bag_weight = bw;
        s.class_weight = cok ? hist_cls[c] : '0;
        s.total_weight = hist_grand;
        s.best_class = best[3:0];
        s.best_class_in_bag = bib[3:0];
        s.bag_correct = corr;
        s.bag_incorrect = sat_acc($signed({{2{bw[ACC_W-1]}}, bw}) -
                                  $signed({{2{corr[ACC_W-1]}}, corr}));
        s.heaviest_bag = heavy[4:0];
        s.split_ok = okcnt > 1;
        s.nonempty_bags = neb[4:0];
        s.nonempty_classes = nec[4:0];
        return s;
    endfunction

    // Mostly short gaps, with an occasional long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // The enable drops for one cycle after each write, so that two writes in a
    // row never assign it twice in the same time step.
    task automatic write_register(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_BAGS) cfg_bags = val[4:0];
        else if (idx == CFG_CLASSES) cfg_classes = val[4:0];
        else if (idx == CFG_MIN) cfg_min = val;
        @(posedge i_clk);
    endtask

    // Wait for all outstanding results, then let the unit settle before a write.
    task automatic wait_idle();
        while (pending_summaries.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Present one item; the transfer completes at an edge with valid and ready high.
    // The expected summary is queued at that edge, before the result can return.
    // Valid is then lowered while the unit is still busy.
    task automatic send_item(input logic [2:0] op, input logic [3:0] b, input logic [3:0] tb,
            input logic [3:0] c, input logic [WGT_W-1:0] w, input bit chk_total,
            input logic [ACC_W-1:0] total);
        t_summary s;
        int g;
        g = gap_len();
        repeat (g) @(posedge i_clk);
        item_ch.valid <= 1'b1;
        item_ch.opcode <= op;
        item_ch.bag <= b;
        item_ch.to_bag <= tb;
        item_ch.class_index <= c;
        item_ch.weight <= w;
        do @(posedge i_clk); while (!item_ch.ready);
        s = apply_histogram_item(op, b, tb, c, w);
        if (chk_total && s.total_weight !== total) begin
            $error("directed total_weight: expected %h, predicted %h", total, s.total_weight);
            fail_count++;
        end
        pending_summaries = {pending_summaries, s};
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_item();
        logic [2:0] op;
        logic [WGT_W-1:0] w;
        int r;
        int nb;
        int nc;
        nb = active_limit(cfg_bags, MAX_BAGS);
        nc = active_limit(cfg_classes, MAX_CLASSES);
        r = $urandom_range(0, 99);
        // Mostly adds, so the table fills up and the scans see real contents.
        if (r < 2) op = OP_CLEAR;
        else if (r < 55) op = OP_ADD;
        else if (r < 72) op = OP_SUB;
        else if (r < 90) op = OP_SHIFT;
        else if (r < 96) op = OP_QUERY;
        else op = 3'($urandom_range(5, 7));
        r = $urandom_range(0, 99);
        if (r < 70) w = $urandom_range(0, 32'h0004_0000);
        else if (r < 90) w = $urandom();
        else w = 32'hFFFF_FFFF;
        // Usually stay inside the active ranges; now and then name an inactive entry.
        send_item(op,
            ($urandom_range(0, 9) == 0) ? 4'($urandom()) : 4'($urandom_range(0, nb-1)),
            ($urandom_range(0, 9) == 0) ? 4'($urandom()) : 4'($urandom_range(0, nb-1)),
            ($urandom_range(0, 9) == 0) ? 4'($urandom()) : 4'($urandom_range(0, nc-1)),
            w, 1'b0, '0);
    endtask

    // Result side: random back-pressure and field-by-field comparison.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            res_stall_max <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (pending_summaries.size() == 0) begin
                    $error("result transfer with no item outstanding");
                    fail_count++;
                end else begin
                    t_summary e;
                    e = pending_summaries.pop_front();
                    if (res_ch.cell_weight !== e.cell_weight) begin
                        $error("cell_weight: expected %h, got %h", e.cell_weight, res_ch.cell_weight);
                        fail_count++;
                    end
                    if (res_ch.bag_weight !== e.bag_weight) begin
                        $error("bag_weight: expected %h, got %h", e.bag_weight, res_ch.bag_weight);
                        fail_count++;
                    end
                    if (res_ch.class_weight !== e.class_weight) begin
                        $error("class_weight: expected %h, got %h", e.class_weight,
                               res_ch.class_weight);
                        fail_count++;
                    end
                    if (res_ch.total_weight !== e.total_weight) begin
                        $error("total_weight: expected %h, got %h", e.total_weight,
                               res_ch.total_weight);
                        fail_count++;
                    end
                    if (res_ch.best_class !== e.best_class) begin
                        $error("best_class: expected %0d, got %0d", e.best_class, res_ch.best_class);
                        fail_count++;
                    end
                    if (res_ch.best_class_in_bag !== e.best_class_in_bag) begin
                        $error("best_class_in_bag: expected %0d, got %0d", e.best_class_in_bag,
                               res_ch.best_class_in_bag);
                        fail_count++;
                    end
                    if (res_ch.bag_correct !== e.bag_correct) begin
                        $error("bag_correct: expected %h, got %h", e.bag_correct, res_ch.bag_correct);
                        fail_count++;
                    end
                    if (res_ch.bag_incorrect !== e.bag_incorrect) begin
                        $error("bag_incorrect: expected %h, got %h", e.bag_incorrect,
                               res_ch.bag_incorrect);
                        fail_count++;
                    end
                    if (res_ch.heaviest_bag !== e.heaviest_bag) begin
                        $error("heaviest_bag: expected %0d, got %0d", e.heaviest_bag,
                               res_ch.heaviest_bag);
                        fail_count++;
                    end
                    if (res_ch.split_ok !== e.split_ok) begin
                        $error("split_ok: expected %0d, got %0d", e.split_ok, res_ch.split_ok);
                        fail_count++;
                    end
                    if (res_ch.nonempty_bags !== e.nonempty_bags) begin
                        $error("nonempty_bags: expected %0d, got %0d", e.nonempty_bags,
                               res_ch.nonempty_bags);
                        fail_count++;
                    end
                    if (res_ch.nonempty_classes !== e.nonempty_classes) begin
                        $error("nonempty_classes: expected %0d, got %0d", e.nonempty_classes,
                               res_ch.nonempty_classes);
                        fail_count++;
                    end
                end
            end
            // Stall decisions come from a counter so that ready is assigned once per edge.
            if (res_stall_max > 0) begin
                res_stall_max <= res_stall_max - 1;
                res_ch.ready <= 1'b0;
            end else if (stim_done) begin
                res_ch.ready <= 1'b1;
            end else begin
                res_stall_max <= gap_len();
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog over the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Directed rows: extremes, every defined opcode and two spare ones, inactive entries, equal-bag shift.
    t_row directed [] = '{
        '{OP_QUERY, 4'd0, 4'd0, 4'd0, 32'h0, 1'b1, 40'h0},
        '{OP_ADD, 4'd0, 4'd0, 4'd0, 32'h0001_0000, 1'b1, 40'h1_0000},
        '{OP_ADD, 4'd1, 4'd0, 4'd1, 32'h0003_0000, 1'b1, 40'h4_0000},
        '{OP_ADD, 4'd15, 4'd0, 4'd0, 32'h0005_0000, 1'b1, 40'h4_0000},
        '{OP_ADD, 4'd0, 4'd0, 4'd15, 32'h0005_0000, 1'b1, 40'h4_0000},
        '{OP_SHIFT, 4'd1, 4'd0, 4'd1, 32'h0002_0000, 1'b1, 40'h4_0000},
        '{OP_SHIFT, 4'd0, 4'd0, 4'd1, 32'h0001_0000, 1'b1, 40'h4_0000},
        '{OP_SHIFT, 4'd0, 4'd15, 4'd0, 32'h0001_0000, 1'b1, 40'h4_0000},
        '{OP_SUB, 4'd1, 4'd0, 4'd1, 32'hFFFF_FFFF, 1'b0, 40'h0},
        '{OP_SPARE, 4'd1, 4'd15, 4'd15, 32'hFFFF_FFFF, 1'b0, 40'h0},
        '{OP_UNUSED, 4'd0, 4'd0, 4'd0, 32'h0, 1'b0, 40'h0},
        '{OP_CLEAR, 4'd15, 4'd15, 4'd15, 32'hFFFF_FFFF, 1'b1, 40'h0},
        '{OP_SUB, 4'd0, 4'd0, 4'd0, 32'h0001_0000, 1'b1, 40'hFF_FFFF_0000},
        '{OP_CLEAR, 4'd0, 4'd0, 4'd0, 32'h0, 1'b1, 40'h0}
    };

    initial begin
        logic [WGT_W-1:0] big;
        fail_count = 0;
        cycle_count = 0;
        stim_done = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_BAGS;
        i_cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.opcode = OP_QUERY;
        item_ch.bag = '0;
        item_ch.to_bag = '0;
        item_ch.class_index = '0;
        item_ch.weight = '0;
        cfg_bags = 5'd2;
        cfg_classes = 5'd2;
        cfg_min = 32'd131072;
        hist_grand = '0;
        foreach (hist_cell[k]) hist_cell[k] = '0;
        foreach (hist_bag[k]) hist_bag[k] = '0;
        foreach (hist_cls[k]) hist_cls[k] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k])
            send_item(directed[k].op, directed[k].bag, directed[k].to_bag, directed[k].cls,
                      directed[k].wgt, directed[k].chk_total, directed[k].total);

        // Full-width settings, then saturation at the top of the accumulator range.
        wait_idle();
        write_register(CFG_BAGS, 32'd16);
        write_register(CFG_CLASSES, 32'd16);
        write_register(CFG_MIN, 32'hFFFF_FFFF);
        big = 32'hFFFF_FFFF;
        repeat (140) send_item(OP_ADD, 4'd15, 4'd15, 4'd15, big, 1'b0, '0);
        send_item(OP_SHIFT, 4'd15, 4'd14, 4'd15, big, 1'b0, '0);
        send_item(OP_SHIFT, 4'd15, 4'd15, 4'd15, big, 1'b0, '0);
        send_item(OP_CLEAR, 4'd0, 4'd0, 4'd0, 32'h0, 1'b0, '0);

        // Random phases over a spread of settings; zero and out-of-range counts
        // are clamped, and the table keeps its values across the changes.
        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    write_register(CFG_BAGS, 32'd0);
                    write_register(CFG_CLASSES, 32'd1);
                    write_register(CFG_MIN, 32'd0);
                end
                1: begin
                    write_register(CFG_BAGS, 32'd31);
                    write_register(CFG_CLASSES, 32'd31);
                    write_register(CFG_MIN, 32'h0001_0000);
                end
                2: begin
                    write_register(CFG_BAGS, 32'd2);
                    write_register(CFG_CLASSES, 32'd2);
                    write_register(CFG_MIN, 32'h0002_0000);
                end
                3: begin
                    write_register(CFG_BAGS, 32'd16);
                    write_register(CFG_CLASSES, 32'd0);
                    write_register(CFG_MIN, 32'hFFFF_FFFF);
                end
                default: begin
                    write_register(CFG_BAGS, $urandom_range(1, 16));
                    write_register(CFG_CLASSES, $urandom_range(1, 16));
                    write_register(CFG_MIN, $urandom_range(0, 32'h0008_0000));
                end
            endcase
            repeat (95) random_item();
        end

        stim_done = 1'b1;
        while (pending_summaries.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
